[hdl/b64d_pkg.sv]
// shared types, constants and the character decode function for the base64 decoder
package b64d_pkg;

   localparam int unsigned SYMBOL_W  = 8;
   localparam int unsigned SEXTET_W  = 6;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned ACC_W     = 3 * SEXTET_W;
   localparam int unsigned TRIPLE_W  = 4 * SEXTET_W;
   localparam int unsigned CNT_W     = 2;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SYMBOL_W-1:0] PAD_CHAR   = 8'h3D;
   localparam logic [SYMBOL_W-1:0] PLUS_CHAR  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] SLASH_CHAR = 8'h2F;

   localparam logic [1:0] POS_LAST = 2'd3;

   // one finished group (or one error) handed from front to back
   typedef struct packed {
      logic [TRIPLE_W-1:0] triple;
      logic [CNT_W-1:0]    count;   // bytes to emit, 1 to 3
      logic                eoi;
      logic                err;
   } job_type;

   // queue status seen by front and back
   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

   function automatic logic [SEXTET_W-1:0] sextet_of(input logic [SYMBOL_W-1:0] c);
      logic [SEXTET_W-1:0] s;
      s = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s = SEXTET_W'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s = SEXTET_W'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s = SEXTET_W'(c - 8'h30 + 8'd52);
      end else if (c == PLUS_CHAR) begin
         s = 6'd62;
      end else if (c == SLASH_CHAR) begin
         s = 6'd63;
      end
      return s;
   endfunction

endpackage

[hdl/base64_stream_decoder_top.sv]
// base64 stream decoder: one character in per request, decoded bytes out
//
// request channel (req_*): one base64 character per request in req_tdata, with
// req_tlast set on the final character of the encoded text.
// response channel (rsp_*): one decoded byte per response in rsp_tdata; rsp_tlast
// marks the last byte caused by one character, rsp_tuser carries the stream end
// and length error flags. a group of four characters yields one to three bytes
// ('=' in the third or fourth place drops trailing bytes); an end mark inside an
// incomplete group yields one error response with a zero byte.
// the front end takes one character per cycle while the queue has room and
// pushes a finished group into a four-entry job queue; the back end emits one
// byte per cycle into an output register while the receiver is ready. a group's
// first byte passes the queue slot, then the output register; the other bytes
// follow one per cycle. sustained rate is one character per cycle, since a group
// of four characters yields at most three bytes. when the receiver stalls, the
// output register holds and the queue fills; req_tready drops only while the
// queue is full. reset clears the group state, the queue and the response valid flag.
module base64_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser    // [0] stream_end, [1] length_error
);

   b64d_pkg::queue_status_type q_status;
   b64d_pkg::job_type          push_job;
   b64d_pkg::job_type          head_job;
   logic                       push;
   logic                       pop;
   logic                       stream_end;
   logic                       length_error;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_symbol (req_tdata),
      .req_eoi    (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   b64d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (head_job),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_data_byte    (rsp_tdata),
      .rsp_run_last     (rsp_tlast),
      .rsp_stream_end   (stream_end),
      .rsp_length_error (length_error)
   );

   assign rsp_tuser = {length_error, stream_end};

endmodule

[hdl/b64d_front.sv]
// front end: accepts characters, gathers groups of four and queues decode jobs
module b64d_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [b64d_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic                               req_eoi,
   input  b64d_pkg::queue_status_type         q_status,
   output logic                               push,
   output b64d_pkg::job_type                  push_job
);

   logic [b64d_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [1:0]                    pos_ff, pos_in;
   logic                          third_pad_ff, third_pad_in;
   logic                          accept;
   logic                          is_pad;
   logic [b64d_pkg::SEXTET_W-1:0] sextet;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign sextet     = b64d_pkg::sextet_of(req_symbol);
   assign is_pad     = (req_symbol == b64d_pkg::PAD_CHAR);

   always_comb begin
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      third_pad_in = third_pad_ff;
      push         = 1'b0;
      push_job     = '0;
      if (accept) begin
         if (pos_ff == b64d_pkg::POS_LAST) begin
            push            = 1'b1;
            push_job.triple = {acc_ff, sextet};
            push_job.count  = 2'd3 - b64d_pkg::CNT_W'(third_pad_ff)
                              - b64d_pkg::CNT_W'(is_pad);
            push_job.eoi    = req_eoi;
            acc_in          = '0;
            pos_in          = '0;
            third_pad_in    = 1'b0;
         end else if (req_eoi) begin
            // end mark inside an incomplete group
            push           = 1'b1;
            push_job.count = 2'd1;
            push_job.eoi   = 1'b1;
            push_job.err   = 1'b1;
            acc_in         = '0;
            pos_in         = '0;
            third_pad_in   = 1'b0;
         end else begin
            acc_in = {acc_ff[b64d_pkg::ACC_W-b64d_pkg::SEXTET_W-1:0], sextet};
            pos_in = pos_ff + 2'd1;
            if (pos_ff == 2'd2) begin
               third_pad_in = is_pad;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= '0;
         third_pad_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         third_pad_ff <= third_pad_in;
      end
   end

endmodule

[hdl/b64d_queue.sv]
// short job queue between the front end and the byte emitter
module b64d_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64d_pkg::job_type          push_job,
   input  logic                       pop,
   output b64d_pkg::job_type          head_job,
   output b64d_pkg::queue_status_type q_status
);

   b64d_pkg::job_type                 slot_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_pop;

   assign q_status.head_valid = (count_ff != '0);
   assign q_status.full       = (count_ff == b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
   assign head_job            = slot_ff[rd_ptr_ff];
   assign do_pop              = pop && q_status.head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hdl/b64d_back.sv]
// back end: splits each queued group into bytes and drives the response register
module b64d_back (
   input  logic                           clock,
   input  logic                           reset,
   input  b64d_pkg::job_type              head_job,
   input  b64d_pkg::queue_status_type     q_status,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [b64d_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic                           rsp_run_last,
   output logic                           rsp_stream_end,
   output logic                           rsp_length_error
);

   logic [b64d_pkg::CNT_W-1:0]  kidx_ff, kidx_in;
   logic                        valid_ff, valid_in;
   logic [b64d_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        end_ff, end_in;
   logic                        err_ff, err_in;
   logic                        load;
   logic                        is_last;
   logic [b64d_pkg::BYTE_W-1:0] sel_byte;

   assign load    = q_status.head_valid && (!valid_ff || rsp_tready);
   assign is_last = (kidx_ff == head_job.count - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      unique case (kidx_ff)
         2'd0:    sel_byte = head_job.triple[23:16];
         2'd1:    sel_byte = head_job.triple[15:8];
         2'd2:    sel_byte = head_job.triple[7:0];
         default: sel_byte = '0;
      endcase
   end

   always_comb begin
      kidx_in  = kidx_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_job.err ? '0 : sel_byte;
         last_in  = is_last;
         end_in   = is_last && head_job.eoi;
         err_in   = head_job.err;
         kidx_in  = is_last ? '0 : kidx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kidx_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         kidx_ff  <= kidx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      end_ff  <= end_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid       = valid_ff;
   assign rsp_data_byte    = byte_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_stream_end   = end_ff;
   assign rsp_length_error = err_ff;

endmodule

[hdl/b64d_checker.sv]
// port-level checks for the base64 stream decoder, bound to the top level
module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   // a waiting request stays offered with the same character
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("waiting request changed");

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // an error response is a lone zero byte that closes the stream
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tuser[0] && rsp_tdata == 8'h00)
      else $error("malformed length error response");

   // stream end only on the last byte of a character
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("stream end without run last");

   // no response can follow reset directly
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
